// File: rtl/surr_pkg.sv
// Shared types and constants for the sensor UART response receiver.
// No dependencies; used by surr_ctrl, surr_dp and the top level.
package surr_pkg;

  localparam int unsigned MAX_READ_BYTES = 16;
  localparam int unsigned BUF_AW         = $clog2(MAX_READ_BYTES);
  localparam int unsigned LEN_W          = BUF_AW + 1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd8000;
  localparam logic [7:0]  HDR_READ_OK   = 8'hBB;
  localparam logic [7:0]  HDR_STATUS    = 8'hEE;
  localparam logic [7:0]  WRITE_ACK     = 8'h01;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_BYTE  = 2'd2,
    REQ_TICK  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STATUS_OK           = 3'd0,
    STATUS_NO_RESP      = 3'd1,
    STATUS_UART_ERR     = 3'd2,
    STATUS_BAD_HDR      = 3'd3,
    STATUS_LEN_MISMATCH = 3'd4,
    STATUS_DEV_ERR      = 3'd5
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    open_rd;
    logic    open_wr;
    logic    tick_inc;
    logic    tick_clr;
    logic    hdr_capture;
    logic    buf_wr;
    logic    drain_clr;
    logic    drain_inc;
    logic    load_data;
    logic    fin;
    status_e fin_status;
    logic    fin_code;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_write;
    logic err_hdr;
    logic tick_hit;
    logic byte_ee;
    logic byte_bb;
    logic byte_ack;
    logic len_match;
    logic len_zero;
    logic rx_done;
    logic drain_last;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/sensor_uart_response_receiver_core.sv
// Sensor UART response receiver, top level.
// Depends on surr_pkg, surr_ctrl and surr_dp.
//
// Input stream (s_axis): one word per event. tuser carries the event kind
// (start read, start write, received byte, time tick); tdata carries the
// requested length, the received byte and its UART error flag.
// Output stream (m_axis): one word per result. A failed or non-data
// transaction yields a single status word with tlast set; a good read
// yields one word per data byte, tlast on the final one.
// Configuration: cfg_we_i loads the 16-bit timeout in ticks (reset 8000).
// Latency: a status word appears the cycle after the accepting edge.
// A completed read is drained from the byte buffer one byte at a time
// (registered buffer read, then output load), and output stalls hold it up;
// s_axis_tready stays low throughout the drain.
// Otherwise one event is taken per cycle while the output register is free.
// Reset returns to idle with no open transaction and no pending word; the
// buffer needs no clearing. A stalled m_axis holds its word and holds off
// new input until the word is taken.
module sensor_uart_response_receiver_core
  import surr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] req_length, [15:8] rx_byte, [16] rx_error
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] device_code, [15:8] data_byte, [19:16] data_index
  output logic [3:0]  m_axis_tuser,  // [2:0] status, [3] has_data
  output logic        m_axis_tlast
);

  cmd_t    cmd;
  stat_t   stat;
  status_e out_status;
  logic [7:0] out_code;
  logic [7:0] out_data;
  logic [3:0] out_index;
  logic       out_has_data;

  surr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .req_type_i (req_e'(s_axis_tuser)),
    .rx_error_i (s_axis_tdata[16]),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  surr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_length_i   (s_axis_tdata[7:0]),
    .rx_byte_i      (s_axis_tdata[15:8]),
    .cmd_i          (cmd),
    .out_ready_i    (m_axis_tready),
    .stat_o         (stat),
    .out_valid_o    (m_axis_tvalid),
    .out_status_o   (out_status),
    .out_code_o     (out_code),
    .out_data_o     (out_data),
    .out_index_o    (out_index),
    .out_has_data_o (out_has_data),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {4'h0, out_index, out_data, out_code};
  assign m_axis_tuser = {out_has_data, out_status};

  // data words are always good-status words without a device code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] == STATUS_OK &&
                                         m_axis_tdata[7:0] == 8'h00)
    else $error("data word with non-ok status");

  // a word without data always closes its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tlast)
    else $error("status word without tlast");

  // input is never taken while a result word is stuck at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("input accepted while output stalled");

endmodule

// File: rtl/surr_ctrl.sv
// Transaction controller: response phases and read-back drain sequencing.
// Depends on surr_pkg; drives surr_dp through cmd_t, observes stat_t.
module surr_ctrl
  import surr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  req_e  req_type_i,
  input  logic  rx_error_i,
  input  stat_t stat_i,
  output logic  in_ready_o,
  output cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_HDR      = 3'd1;
  localparam logic [2:0] ST_SEC      = 3'd2;
  localparam logic [2:0] ST_DATA     = 3'd3;
  localparam logic [2:0] ST_DRAIN_RD = 3'd4;
  localparam logic [2:0] ST_DRAIN_WR = 3'd5;

  logic [2:0] state_q, state_d;
  logic       draining;
  logic       accept;

  assign draining   = (state_q == ST_DRAIN_RD) || (state_q == ST_DRAIN_WR);
  assign in_ready_o = !draining && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.fin_status = STATUS_OK;

    if (accept) begin
      case (req_type_i)
        REQ_READ: begin
          cmd_o.open_rd = 1'b1;
          state_d = ST_HDR;
        end
        REQ_WRITE: begin
          cmd_o.open_wr = 1'b1;
          state_d = ST_HDR;
        end
        REQ_TICK: begin
          if (state_q != ST_IDLE) begin
            cmd_o.tick_inc = 1'b1;
            if (stat_i.tick_hit) begin
              cmd_o.fin = 1'b1;
              cmd_o.fin_status = STATUS_NO_RESP;
            end
          end
        end
        default: begin
          if (state_q != ST_IDLE) begin
            cmd_o.tick_clr = 1'b1;
            if (rx_error_i) begin
              cmd_o.fin = 1'b1;
              cmd_o.fin_status = STATUS_UART_ERR;
            end else if (state_q == ST_HDR) begin
              if (stat_i.is_write ? !stat_i.byte_ee : !(stat_i.byte_ee || stat_i.byte_bb)) begin
                cmd_o.fin = 1'b1;
                cmd_o.fin_status = STATUS_BAD_HDR;
              end else begin
                cmd_o.hdr_capture = 1'b1;
                state_d = ST_SEC;
              end
            end else if (state_q == ST_SEC) begin
              if (stat_i.is_write) begin
                cmd_o.fin = 1'b1;
                cmd_o.fin_status = stat_i.byte_ack ? STATUS_OK : STATUS_DEV_ERR;
                cmd_o.fin_code = !stat_i.byte_ack;
              end else if (stat_i.err_hdr) begin
                cmd_o.fin = 1'b1;
                cmd_o.fin_status = STATUS_DEV_ERR;
                cmd_o.fin_code = 1'b1;
              end else if (!stat_i.len_match) begin
                cmd_o.fin = 1'b1;
                cmd_o.fin_status = STATUS_LEN_MISMATCH;
              end else if (stat_i.len_zero) begin
                cmd_o.fin = 1'b1;
                cmd_o.fin_status = STATUS_OK;
              end else begin
                state_d = ST_DATA;
              end
            end else begin
              cmd_o.buf_wr = 1'b1;
              if (stat_i.rx_done) begin
                cmd_o.drain_clr = 1'b1;
                state_d = ST_DRAIN_RD;
              end
            end
          end
        end
      endcase
      if (cmd_o.fin) begin
        state_d = ST_IDLE;
      end
    end else begin
      unique case (state_q)
        // buffer read is registered: fetch in ST_DRAIN_RD, then hand off in ST_DRAIN_WR
        ST_DRAIN_RD: state_d = ST_DRAIN_WR;
        ST_DRAIN_WR: begin
          if (stat_i.out_free) begin
            cmd_o.load_data = 1'b1;
            if (stat_i.drain_last) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.drain_inc = 1'b1;
              state_d = ST_DRAIN_RD;
            end
          end
        end
        default: state_d = state_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/surr_dp.sv
// Datapath: timeout register and counter, length/byte counters, read buffer,
// result register. Depends on surr_pkg; commanded by surr_ctrl.
module surr_dp
  import surr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic [7:0]    req_length_i,
  input  logic [7:0]    rx_byte_i,
  input  cmd_t          cmd_i,
  input  logic          out_ready_i,
  output stat_t         stat_o,
  output logic          out_valid_o,
  output status_e       out_status_o,
  output logic [7:0]    out_code_o,
  output logic [7:0]    out_data_o,
  output logic [3:0]    out_index_o,
  output logic          out_has_data_o,
  output logic          out_last_o
);

  logic [15:0]       timeout_q;
  logic [15:0]       tick_q;
  logic [16:0]       tick_next;
  logic              is_write_q;
  logic              err_hdr_q;
  logic [LEN_W-1:0]  exp_len_q;
  logic [LEN_W-1:0]  rcv_cnt_q;
  logic [LEN_W-1:0]  rcv_cnt_inc;
  logic [LEN_W-1:0]  len_clamped;
  logic [BUF_AW-1:0] drain_idx_q;
  logic [LEN_W-1:0]  drain_idx_inc;
  logic [7:0]        buf_mem [MAX_READ_BYTES];
  logic [7:0]        rd_data_q;
  logic              out_valid_q;

  assign tick_next     = {1'b0, tick_q} + 17'd1;
  assign rcv_cnt_inc   = rcv_cnt_q + LEN_W'(1);
  assign drain_idx_inc = {1'b0, drain_idx_q} + LEN_W'(1);
  assign len_clamped   = (req_length_i > 8'(MAX_READ_BYTES)) ? LEN_W'(MAX_READ_BYTES)
                                                             : req_length_i[LEN_W-1:0];

  always_comb begin
    stat_o.is_write   = is_write_q;
    stat_o.err_hdr    = err_hdr_q;
    // a timeout of 0 behaves as 1 since tick_next is never 0
    stat_o.tick_hit   = tick_next >= {1'b0, timeout_q};
    stat_o.byte_ee    = rx_byte_i == HDR_STATUS;
    stat_o.byte_bb    = rx_byte_i == HDR_READ_OK;
    stat_o.byte_ack   = rx_byte_i == WRITE_ACK;
    stat_o.len_match  = rx_byte_i == 8'(exp_len_q);
    stat_o.len_zero   = exp_len_q == '0;
    stat_o.rx_done    = rcv_cnt_inc >= exp_len_q;
    stat_o.drain_last = drain_idx_inc == exp_len_q;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TIMEOUT_RESET;
      tick_q      <= '0;
      is_write_q  <= 1'b0;
      err_hdr_q   <= 1'b0;
      exp_len_q   <= '0;
      rcv_cnt_q   <= '0;
      drain_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (cmd_i.open_rd || cmd_i.open_wr) begin
        is_write_q <= cmd_i.open_wr;
        exp_len_q  <= cmd_i.open_rd ? len_clamped : '0;
        rcv_cnt_q  <= '0;
        tick_q     <= '0;
        err_hdr_q  <= 1'b0;
      end else begin
        if (cmd_i.tick_inc) begin
          tick_q <= tick_next[15:0];
        end else if (cmd_i.tick_clr) begin
          tick_q <= '0;
        end
        if (cmd_i.hdr_capture) begin
          err_hdr_q <= stat_o.byte_ee;
        end
        if (cmd_i.buf_wr) begin
          rcv_cnt_q <= rcv_cnt_inc;
        end
      end
      if (cmd_i.drain_clr) begin
        drain_idx_q <= '0;
      end else if (cmd_i.drain_inc) begin
        drain_idx_q <= drain_idx_inc[BUF_AW-1:0];
      end
      if (cmd_i.fin || cmd_i.load_data) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // read buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_wr) begin
      buf_mem[rcv_cnt_q[BUF_AW-1:0]] <= rx_byte_i;
    end
    rd_data_q <= buf_mem[drain_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_status_o   <= cmd_i.fin_status;
      out_code_o     <= cmd_i.fin_code ? rx_byte_i : 8'h00;
      out_data_o     <= 8'h00;
      out_index_o    <= 4'd0;
      out_has_data_o <= 1'b0;
      out_last_o     <= 1'b1;
    end else if (cmd_i.load_data) begin
      out_status_o   <= STATUS_OK;
      out_code_o     <= 8'h00;
      out_data_o     <= rd_data_q;
      out_index_o    <= 4'(drain_idx_q);
      out_has_data_o <= 1'b1;
      out_last_o     <= stat_o.drain_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
